[src/cmts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmts_pkg
// shared types and constants of the c-minus token scanner: token kinds,
// scanner states, reserved word table and the result item layout
// ----------------------------------------------------------------------------
package cmts_pkg;

    localparam int unsigned CMTS_MAX_TOKEN_LEN = 40;

    localparam int unsigned KIND_W = 5;
    localparam int unsigned LEN_W  = 6;
    localparam int unsigned LINE_W = 16;
    localparam int unsigned CHAR_W = 8;

    // token kinds
    localparam logic [KIND_W-1:0] K_ENDFILE = 5'd0;
    localparam logic [KIND_W-1:0] K_ERROR   = 5'd1;
    localparam logic [KIND_W-1:0] K_IF      = 5'd2;
    localparam logic [KIND_W-1:0] K_ID      = 5'd8;
    localparam logic [KIND_W-1:0] K_NUM     = 5'd9;
    localparam logic [KIND_W-1:0] K_ASSIGN  = 5'd10;
    localparam logic [KIND_W-1:0] K_EQ      = 5'd11;
    localparam logic [KIND_W-1:0] K_NE      = 5'd12;
    localparam logic [KIND_W-1:0] K_LT      = 5'd13;
    localparam logic [KIND_W-1:0] K_LE      = 5'd14;
    localparam logic [KIND_W-1:0] K_GT      = 5'd15;
    localparam logic [KIND_W-1:0] K_GE      = 5'd16;
    localparam logic [KIND_W-1:0] K_PLUS    = 5'd17;
    localparam logic [KIND_W-1:0] K_MINUS   = 5'd18;
    localparam logic [KIND_W-1:0] K_TIMES   = 5'd19;
    localparam logic [KIND_W-1:0] K_OVER    = 5'd20;
    localparam logic [KIND_W-1:0] K_LPAREN  = 5'd21;
    localparam logic [KIND_W-1:0] K_RPAREN  = 5'd22;
    localparam logic [KIND_W-1:0] K_LBRACK  = 5'd23;
    localparam logic [KIND_W-1:0] K_RBRACK  = 5'd24;
    localparam logic [KIND_W-1:0] K_LCURLY  = 5'd25;
    localparam logic [KIND_W-1:0] K_RCURLY  = 5'd26;
    localparam logic [KIND_W-1:0] K_SEMI    = 5'd27;
    localparam logic [KIND_W-1:0] K_COMMA   = 5'd28;

    localparam logic [LINE_W-1:0] LINE_MAX = 16'hFFFF;

    // characters with a role of their own
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_BLANK   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;

    typedef enum logic [3:0] {
        ST_START = 4'd0,
        ST_NUM   = 4'd1,
        ST_ID    = 4'd2,
        ST_EQ    = 4'd3,
        ST_LT    = 4'd4,
        ST_GT    = 4'd5,
        ST_NE    = 4'd6,
        ST_OVER  = 4'd7,
        ST_CMT   = 4'd8,
        ST_CSTAR = 4'd9
    } scan_state_t;

    // reserved words: if else while return int void
    localparam int unsigned RW_COUNT   = 6;
    localparam int unsigned RW_MAX_LEN = 6;

    localparam logic [CHAR_W-1:0] RW_CHAR [RW_COUNT][RW_MAX_LEN] = '{
        '{"i", "f", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"e", "l", "s", "e", CH_NUL, CH_NUL},
        '{"w", "h", "i", "l", "e", CH_NUL},
        '{"r", "e", "t", "u", "r", "n"},
        '{"i", "n", "t", CH_NUL, CH_NUL, CH_NUL},
        '{"v", "o", "i", "d", CH_NUL, CH_NUL}
    };

    localparam logic [LEN_W-1:0] RW_LEN [RW_COUNT] = '{
        6'd2, 6'd4, 6'd5, 6'd6, 6'd3, 6'd4
    };

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [LEN_W-1:0]  len;
        logic [LINE_W-1:0] line;
        logic              last;
    } tok_t;

endpackage

[src/c_minus_token_scanner_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_minus_token_scanner_core
// dfa lexical scanner for c-minus: one source character per item in,
// tokens (kind, length, line, last-of-run) out
// ----------------------------------------------------------------------------
// The scanner takes one character item per cycle and updates its DFA in the
// same cycle; the tokens an item causes appear on the token port on the next
// cycle. An item causes zero, one or two tokens (two when a character ends a
// pending token and then starts or forms one itself, or when end of input
// closes a pending token before endfile). Tokens leave through a two-entry
// result queue, one per cycle while not stalled: a stream where each item
// causes at most one token runs at one item per cycle, and an item that
// causes two tokens holds off the next item until the single token port
// drains the queue. The character side is held off while the queue could
// not take two more tokens. token_length counts saved lexeme characters,
// capped at MAX_TOKEN_LEN; line_number saturates at 65535. After end of
// input every item yields one endfile token until reset.
// ----------------------------------------------------------------------------
module c_minus_token_scanner_core #(
    parameter int unsigned MAX_TOKEN_LEN = cmts_pkg::CMTS_MAX_TOKEN_LEN
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // character item channel
    input  logic                         src_valid,
    output logic                         src_stall,
    input  logic [cmts_pkg::CHAR_W-1:0]  char_code,
    input  logic                         end_of_input,
    // token item channel
    output logic                         tok_valid,
    input  logic                         tok_stall,
    output logic [cmts_pkg::KIND_W-1:0]  token_kind,
    output logic [cmts_pkg::LEN_W-1:0]   token_length,
    output logic [cmts_pkg::LINE_W-1:0]  line_number,
    output logic                         last_of_run
);
    import cmts_pkg::*;

    localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_TOKEN_LEN);

    // scanner state
    scan_state_t          state_reg, state_next;
    logic [LEN_W-1:0]     cnt_reg, cnt_next;
    logic [RW_COUNT-1:0]  rmatch_reg, rmatch_next;
    logic [LINE_W-1:0]    line_reg, line_next;
    logic                 ended_reg, ended_next;

    // result queue: q0 is on the port, q1 waits behind it
    tok_t                 q0_reg, q0_next;
    tok_t                 q1_reg, q1_next;
    logic [1:0]           qcnt_reg, qcnt_next;

    logic src_accept;
    logic tok_pop;

    // character classes
    logic is_digit, is_alpha;

    // what a scan from the start state does with this item
    logic                 st_emit;
    logic [KIND_W-1:0]    st_kind;
    logic [LEN_W-1:0]     st_len;
    scan_state_t          st_state;
    logic [LEN_W-1:0]     st_cnt;
    logic [RW_COUNT-1:0]  st_rmatch;
    logic                 st_bump;
    logic                 st_end;

    // token closed by the current state, and whether the character is rescanned
    logic                 p_emit;
    logic [KIND_W-1:0]    p_kind;
    logic [LEN_W-1:0]     p_len;
    logic                 do_start;
    logic                 bump;

    logic [KIND_W-1:0]    id_kind;
    logic [LEN_W-1:0]     cnt_sat_inc;

    // results of this item
    tok_t                 res0, res1;
    logic [1:0]           nres;

    // reserved word bits still alive when character c sits at position pos
    function automatic logic [RW_COUNT-1:0] match_at(input logic [LEN_W-1:0] pos,
                                                     input logic [CHAR_W-1:0] c);
        logic [RW_COUNT-1:0] m;
        m = '0;
        if (pos < LEN_W'(RW_MAX_LEN)) begin
            for (int i = 0; i < RW_COUNT; i++) begin
                m[i] = (RW_CHAR[i][pos[2:0]] == c);
            end
        end
        return m;
    endfunction

    assign src_accept = src_valid && !src_stall;
    assign tok_pop    = tok_valid && !tok_stall;

    // room for two tokens once this cycle's pop is counted
    assign src_stall = !((qcnt_reg == 2'd0) || ((qcnt_reg == 2'd1) && !tok_stall));

    assign is_digit = (char_code >= "0") && (char_code <= "9");
    assign is_alpha = ((char_code >= "a") && (char_code <= "z")) ||
                      ((char_code >= "A") && (char_code <= "Z"));

    assign cnt_sat_inc = (cnt_reg < MaxLen) ? cnt_reg + LEN_W'(1) : cnt_reg;

    // lowest reserved word that is still a match at full length
    always_comb
    begin
        id_kind = K_ID;
        for (int i = RW_COUNT - 1; i >= 0; i--) begin
            if (rmatch_reg[i] && (cnt_reg == RW_LEN[i])) begin
                id_kind = K_IF + KIND_W'(i);
            end
        end
    end

    // scan from the start state
    always_comb
    begin
        st_emit   = 1'b0;
        st_kind   = K_ERROR;
        st_len    = LEN_W'(1);
        st_state  = ST_START;
        st_cnt    = '0;
        st_rmatch = '1;
        st_bump   = 1'b0;
        st_end    = 1'b0;
        if (end_of_input) begin
            st_emit = 1'b1;
            st_kind = K_ENDFILE;
            st_len  = '0;
            st_end  = 1'b1;
        end
        else if (is_digit) begin
            st_state = ST_NUM;
            st_cnt   = LEN_W'(1);
        end
        else if (is_alpha) begin
            st_state  = ST_ID;
            st_cnt    = LEN_W'(1);
            st_rmatch = match_at('0, char_code);
        end
        else begin
            case (char_code) inside
                CH_BLANK, CH_TAB: ;
                CH_NEWLINE: st_bump = 1'b1;
                "=": begin st_state = ST_EQ;   st_cnt = LEN_W'(1); end
                "<": begin st_state = ST_LT;   st_cnt = LEN_W'(1); end
                ">": begin st_state = ST_GT;   st_cnt = LEN_W'(1); end
                "!": begin st_state = ST_NE;   st_cnt = LEN_W'(1); end
                "/": begin st_state = ST_OVER; st_cnt = LEN_W'(1); end
                "+": begin st_emit = 1'b1; st_kind = K_PLUS;   end
                "-": begin st_emit = 1'b1; st_kind = K_MINUS;  end
                "*": begin st_emit = 1'b1; st_kind = K_TIMES;  end
                "(": begin st_emit = 1'b1; st_kind = K_LPAREN; end
                ")": begin st_emit = 1'b1; st_kind = K_RPAREN; end
                "[": begin st_emit = 1'b1; st_kind = K_LBRACK; end
                "]": begin st_emit = 1'b1; st_kind = K_RBRACK; end
                "{": begin st_emit = 1'b1; st_kind = K_LCURLY; end
                "}": begin st_emit = 1'b1; st_kind = K_RCURLY; end
                ";": begin st_emit = 1'b1; st_kind = K_SEMI;   end
                ",": begin st_emit = 1'b1; st_kind = K_COMMA;  end
                default: st_emit = 1'b1;  // anything that starts no token
            endcase
        end
    end

    // main dfa step
    always_comb
    begin
        p_emit      = 1'b0;
        p_kind      = K_ENDFILE;
        p_len       = '0;
        do_start    = 1'b0;
        bump        = 1'b0;
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        rmatch_next = rmatch_reg;
        ended_next  = ended_reg;

        if (ended_reg) begin
            // sticky end: endfile for every item
            p_emit = 1'b1;
        end
        else begin
            unique case (state_reg) inside
                ST_NUM:
                begin
                    if (!end_of_input && is_digit) begin
                        cnt_next = cnt_sat_inc;
                    end
                    else begin
                        p_emit   = 1'b1;
                        p_kind   = K_NUM;
                        p_len    = cnt_reg;
                        do_start = 1'b1;
                    end
                end
                ST_ID:
                begin
                    if (!end_of_input && (is_alpha || is_digit)) begin
                        rmatch_next = rmatch_reg & match_at(cnt_reg, char_code);
                        cnt_next    = cnt_sat_inc;
                    end
                    else begin
                        p_emit   = 1'b1;
                        p_kind   = id_kind;
                        p_len    = cnt_reg;
                        do_start = 1'b1;
                    end
                end
                ST_EQ, ST_LT, ST_GT, ST_NE:
                begin
                    p_emit = 1'b1;
                    if (!end_of_input && (char_code == "=")) begin
                        case (state_reg)
                            ST_EQ:   p_kind = K_EQ;
                            ST_LT:   p_kind = K_LE;
                            ST_GT:   p_kind = K_GE;
                            default: p_kind = K_NE;
                        endcase
                        p_len       = LEN_W'(2);
                        state_next  = ST_START;
                        cnt_next    = '0;
                        rmatch_next = '1;
                    end
                    else begin
                        // lone bang falls out as an error
                        case (state_reg)
                            ST_EQ:   p_kind = K_ASSIGN;
                            ST_LT:   p_kind = K_LT;
                            ST_GT:   p_kind = K_GT;
                            default: p_kind = K_ERROR;
                        endcase
                        p_len    = LEN_W'(1);
                        do_start = 1'b1;
                    end
                end
                ST_OVER:
                begin
                    if (!end_of_input && (char_code == "*")) begin
                        state_next = ST_CMT;
                        cnt_next   = '0;
                    end
                    else begin
                        p_emit   = 1'b1;
                        p_kind   = K_OVER;
                        p_len    = LEN_W'(1);
                        do_start = 1'b1;
                    end
                end
                ST_CMT, ST_CSTAR:
                begin
                    if (end_of_input) begin
                        p_emit      = 1'b1;
                        ended_next  = 1'b1;
                        state_next  = ST_START;
                        cnt_next    = '0;
                        rmatch_next = '1;
                    end
                    else if (char_code == "*") begin
                        state_next = ST_CSTAR;
                    end
                    else if ((state_reg == ST_CSTAR) && (char_code == "/")) begin
                        state_next  = ST_START;
                        cnt_next    = '0;
                        rmatch_next = '1;
                    end
                    else begin
                        bump       = (char_code == CH_NEWLINE);
                        state_next = ST_CMT;
                    end
                end
                ST_START: do_start = 1'b1;
                default:  do_start = 1'b1;  // codes with no meaning act as start
            endcase
        end

        if (do_start) begin
            state_next  = st_state;
            cnt_next    = st_cnt;
            rmatch_next = st_rmatch;
            bump        = st_bump;
            ended_next  = st_end;
        end

        line_next = (bump && (line_reg != LINE_MAX)) ? line_reg + LINE_W'(1) : line_reg;
    end

    // pack the item's tokens in emission order
    always_comb
    begin
        res0 = '{kind: p_kind, len: p_len, line: line_reg, last: 1'b1};
        res1 = '{kind: st_kind, len: st_len, line: line_reg, last: 1'b1};
        nres = 2'd0;
        if (p_emit) begin
            if (do_start && st_emit) begin
                res0.last = 1'b0;
                nres      = 2'd2;
            end
            else begin
                nres = 2'd1;
            end
        end
        else if (do_start && st_emit) begin
            res0 = res1;
            nres = 2'd1;
        end
    end

    // result queue update; an accept only happens with the queue empty after pop
    always_comb
    begin
        q0_next   = q0_reg;
        q1_next   = q1_reg;
        qcnt_next = qcnt_reg;
        if (tok_pop) begin
            q0_next   = q1_reg;
            qcnt_next = qcnt_reg - 2'd1;
        end
        if (src_accept) begin
            q0_next   = res0;
            q1_next   = res1;
            qcnt_next = nres;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= ST_START;
            cnt_reg    <= '0;
            rmatch_reg <= '1;
            line_reg   <= LINE_W'(1);
            ended_reg  <= 1'b0;
            qcnt_reg   <= 2'd0;
        end
        else begin
            if (src_accept) begin
                state_reg  <= state_next;
                cnt_reg    <= cnt_next;
                rmatch_reg <= rmatch_next;
                line_reg   <= line_next;
                ended_reg  <= ended_next;
            end
            qcnt_reg <= qcnt_next;
        end
    end

    // payload of the queue, no reset needed
    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    assign tok_valid    = (qcnt_reg != 2'd0);
    assign token_kind   = q0_reg.kind;
    assign token_length = q0_reg.len;
    assign line_number  = q0_reg.line;
    assign last_of_run  = q0_reg.last;

endmodule

[src/cmts_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmts_checker
// port-level checks of the token scanner, bound to the scanner core
// ----------------------------------------------------------------------------
module cmts_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         tok_valid,
    input logic                         tok_stall,
    input logic [cmts_pkg::KIND_W-1:0]  token_kind,
    input logic [cmts_pkg::LEN_W-1:0]   token_length,
    input logic [cmts_pkg::LINE_W-1:0]  line_number,
    input logic                         last_of_run
);
    import cmts_pkg::*;

    // a stalled token holds
    a_tok_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid && tok_stall) |=>
            (tok_valid && $stable(token_kind) && $stable(token_length) &&
             $stable(line_number) && $stable(last_of_run)))
        else $error("token changed while stalled");

    // endfile is empty and always closes its item
    a_endfile_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid && (token_kind == K_ENDFILE)) |->
            ((token_length == '0) && last_of_run))
        else $error("endfile token with length or not last");

    // nothing but endfile follows endfile
    a_endfile_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid && !tok_stall && (token_kind == K_ENDFILE)) |=>
            (!tok_valid || (token_kind == K_ENDFILE)))
        else $error("token after endfile");

    // operators are one or two characters
    a_op_length: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid && (token_kind >= K_ASSIGN)) |->
            ((token_length == LEN_W'(1)) || (token_length == LEN_W'(2))))
        else $error("operator token with bad length");

    // line numbers never go back
    a_line_order: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid && !tok_stall) |=>
            (!tok_valid || (line_number >= $past(line_number))))
        else $error("line number went backwards");

endmodule

bind c_minus_token_scanner_core cmts_checker u_cmts_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .tok_valid    (tok_valid),
    .tok_stall    (tok_stall),
    .token_kind   (token_kind),
    .token_length (token_length),
    .line_number  (line_number),
    .last_of_run  (last_of_run)
);
